// ===== rtl/core/tst_pkg.sv =====
package tst_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int SLOT_W     = 4;
  localparam int AGE_W      = 3;

  localparam logic [2:0]  AGE_LIMIT  = 3'd4;
  localparam logic [39:0] CTRL_MAGIC = 40'h4E5544504E;
  localparam logic [15:0] CTRL_LEN   = 16'd10;
  localparam logic [7:0]  ID_OFFSET  = 8'd2;

  localparam logic [7:0] CMD_JOIN  = 8'h43;
  localparam logic [7:0] CMD_SUPER = 8'h53;
  localparam logic [7:0] CMD_KEEP  = 8'h4C;

  localparam logic [3:0] VER_4 = 4'd4;
  localparam logic [3:0] VER_6 = 4'd6;

  typedef enum logic [1:0] {
    REQ_NET  = 2'd0,
    REQ_TUN  = 2'd1,
    REQ_TICK = 2'd2,
    REQ_NONE = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ACT_REPLY  = 2'd0,
    ACT_TUNNEL = 2'd1,
    ACT_SEND   = 2'd2
  } act_t;

  typedef enum logic [1:0] {
    RC_ASSIGNED = 2'd0,
    RC_FULL     = 2'd1,
    RC_ECHO     = 2'd2,
    RC_KILL     = 2'd3
  } rc_t;

  // classified event handed from front to back
  typedef struct packed {
    req_t        req;
    logic        is_ctrl;
    logic [7:0]  cmd;
    logic [3:0]  ver;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [15:0] port;
    logic [8:0]  data_cand;   // signed-ish: bit 8 set means negative
    logic [8:0]  tun_cand;
    logic        tun_super;   // use super client
  } evt_t;

  typedef struct packed {
    act_t        action;
    rc_t         code;
    logic [3:0]  slot;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [15:0] port;
    logic        last;
  } res_t;

endpackage

// ===== rtl/core/tst_front.sv =====
module tst_front import tst_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_req_type,
  input  logic [63:0] in_peer_addr_hi,
  input  logic [63:0] in_peer_addr_lo,
  input  logic [15:0] in_peer_port,
  input  logic [15:0] in_pkt_length,
  input  logic [47:0] in_head_bytes,
  input  logic [3:0]  in_ip_ver,
  input  logic [7:0]  in_v4_src_last,
  input  logic [31:0] in_v4_dst_addr,
  input  logic [7:0]  in_v6_src_last,
  input  logic [7:0]  in_v6_dst_last,
  output logic        evt_valid,
  input  logic        evt_pop,
  output evt_t        evt_data
);

  logic [31:0] subnet_r;
  evt_t        cls;
  evt_t        q_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  logic        push_ok;

  // subnet register
  always_ff @(posedge clk) begin
    if (!rst_n) subnet_r <= '0;
    else if (cfg_we) subnet_r <= cfg_wdata;
  end

  // classify the word
  always_comb begin
    cls = '0;
    cls.req     = req_t'(in_req_type);
    cls.is_ctrl = (in_pkt_length == CTRL_LEN) && (in_head_bytes[47:8] == CTRL_MAGIC);
    cls.cmd     = in_head_bytes[7:0];
    cls.ver     = in_ip_ver;
    cls.addr_hi = in_peer_addr_hi;
    cls.addr_lo = in_peer_addr_lo;
    cls.port    = in_peer_port;
    cls.data_cand = 9'h100;
    if (in_ip_ver == VER_4) cls.data_cand = {1'b0, in_v4_src_last} - {1'b0, ID_OFFSET};
    else if (in_ip_ver == VER_6) cls.data_cand = {1'b0, in_v6_src_last} - {1'b0, ID_OFFSET};
    cls.tun_cand  = 9'h100;
    cls.tun_super = 1'b0;
    if (in_ip_ver == VER_4) begin
      if ((in_v4_dst_addr & subnet_r) == subnet_r)
        cls.tun_cand = {1'b0, in_v4_dst_addr[7:0]} - {1'b0, ID_OFFSET};
      else
        cls.tun_super = 1'b1;
    end else if (in_ip_ver == VER_6) begin
      cls.tun_cand = {1'b0, in_v6_dst_last} - {1'b0, ID_OFFSET};
    end
  end

  assign in_full   = (cnt_r == 2'd2);
  assign push_ok   = in_push && !in_full;
  assign evt_valid = (cnt_r != 2'd0);
  assign evt_data  = q_r[rp_r];

  // two-entry queue toward the back end
  always_ff @(posedge clk) begin
    if (push_ok) q_r[wp_r] <= cls;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push_ok) wp_r <= ~wp_r;
      if (evt_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push_ok} - {1'b0, evt_pop};
    end
  end

endmodule

// ===== rtl/core/tst_back.sv =====
module tst_back import tst_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        evt_valid,
  output logic        evt_pop,
  input  evt_t        evt_data,
  output logic        out_empty,
  input  logic        out_pop,
  output res_t        res
);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_OUT1, S_OUT2} state_t;

  state_t      state_r;
  logic [AGE_W-1:0] age_r [SLOT_COUNT];
  logic [63:0] hi_r [SLOT_COUNT];
  logic [63:0] lo_r [SLOT_COUNT];
  logic [15:0] port_r [SLOT_COUNT];
  logic [SLOT_W-1:0] super_slot_r;
  logic        super_valid_r;
  evt_t        e_r;
  logic        hit_r;
  logic [SLOT_W-1:0] hit_id_r;
  res_t        r0_r, r1_r;

  // match and free search on the event at the queue head
  logic        fhit;
  logic [SLOT_W-1:0] fid;
  logic        ffree;
  logic [SLOT_W-1:0] free_id;
  always_comb begin
    fhit = 1'b0; fid = '0; ffree = 1'b0; free_id = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (port_r[i] == evt_data.port && hi_r[i] == evt_data.addr_hi &&
          lo_r[i] == evt_data.addr_lo) begin
        fhit = 1'b1; fid = SLOT_W'(i);
      end
      if (age_r[i] == '0) begin
        ffree = 1'b1; free_id = SLOT_W'(i);
      end
    end
  end

  logic free_ok_r;
  logic [SLOT_W-1:0] free_r;

  assign evt_pop   = (state_r == S_IDLE) && evt_valid;
  assign out_empty = !((state_r == S_OUT1) || (state_r == S_OUT2));
  assign res       = (state_r == S_OUT1) ? r0_r : r1_r;

  logic [SLOT_W-1:0] tid;
  logic              tok;
  logic [SLOT_W-1:0] dslot;
  logic              dok;
  always_comb begin
    tok = 1'b0; tid = '0;
    if (e_r.tun_super) begin
      tok = super_valid_r; tid = super_slot_r;
    end else if (!e_r.tun_cand[8] && e_r.tun_cand[7:0] < 8'(SLOT_COUNT)) begin
      tok = 1'b1; tid = e_r.tun_cand[SLOT_W-1:0];
    end
    tok = tok && (age_r[tid] != '0);
    dok   = !e_r.data_cand[8] && e_r.data_cand[7:0] < 8'(SLOT_COUNT);
    dslot = e_r.data_cand[SLOT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (evt_pop) begin
      e_r       <= evt_data;
      hit_r     <= fhit;
      hit_id_r  <= fid;
      free_ok_r <= ffree;
      free_r    <= free_id;
    end
    if (!rst_n) begin
      state_r <= S_IDLE;
      super_slot_r <= '0;
      super_valid_r <= 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        age_r[i] <= '0; hi_r[i] <= '0; lo_r[i] <= '0; port_r[i] <= '0;
      end
    end else begin
      unique case (state_r)
        S_IDLE: if (evt_valid) state_r <= S_EXEC;
        S_EXEC: begin
          state_r <= S_IDLE;
          r0_r <= '0; r1_r <= '0;
          unique case (e_r.req)
            REQ_NET: begin
              if (hit_r) age_r[hit_id_r] <= AGE_W'(1);
              if (e_r.is_ctrl) begin
                if (e_r.cmd == CMD_JOIN || e_r.cmd == CMD_SUPER) begin
                  if (!hit_r) begin
                    state_r <= S_OUT2;
                    r1_r <= '{ACT_REPLY, RC_FULL, '0, e_r.addr_hi, e_r.addr_lo,
                               e_r.port, 1'b1};
                    if (free_ok_r) begin
                      r1_r.slot <= free_r;
                      r1_r.code <= RC_ASSIGNED;
                      age_r[free_r]  <= AGE_W'(1);
                      hi_r[free_r]   <= e_r.addr_hi;
                      lo_r[free_r]   <= e_r.addr_lo;
                      port_r[free_r] <= e_r.port;
                      if (e_r.cmd == CMD_SUPER) begin
                        super_slot_r  <= free_r;
                        super_valid_r <= 1'b1;
                      end
                    end
                  end
                end else if (e_r.cmd == CMD_KEEP && hit_r) begin
                  state_r <= S_OUT2;
                  r1_r <= '{ACT_REPLY, RC_ECHO, hit_id_r, e_r.addr_hi, e_r.addr_lo,
                             e_r.port, 1'b1};
                end
              end else begin
                state_r <= S_OUT2;
                r1_r <= '{ACT_TUNNEL, RC_ASSIGNED, hit_id_r, '0, '0, '0, 1'b1};
                if (!hit_r) begin
                  r1_r.slot <= '0;
                  if (dok) begin
                    r1_r.slot <= dslot;
                    age_r[dslot]  <= AGE_W'(1);
                    hi_r[dslot]   <= e_r.addr_hi;
                    lo_r[dslot]   <= e_r.addr_lo;
                    port_r[dslot] <= e_r.port;
                  end else if (e_r.ver == VER_4) begin
                    state_r <= S_OUT1;
                    r0_r <= '{ACT_REPLY, RC_KILL, '0, e_r.addr_hi, e_r.addr_lo,
                               e_r.port, 1'b0};
                  end
                end
              end
            end
            REQ_TUN: if (tok) begin
              state_r <= S_OUT2;
              r1_r <= '{ACT_SEND, RC_ASSIGNED, tid, hi_r[tid], lo_r[tid], port_r[tid], 1'b1};
            end
            REQ_TICK: begin
              for (int i = 0; i < SLOT_COUNT; i++) begin
                if (age_r[i] != '0) begin
                  if (age_r[i] > AGE_LIMIT) begin
                    age_r[i] <= '0;
                    if (super_valid_r && super_slot_r == SLOT_W'(i))
                      super_valid_r <= 1'b0;
                  end else begin
                    age_r[i] <= age_r[i] + AGE_W'(1);
                  end
                end
              end
            end
            default: ;
          endcase
        end
        S_OUT1: if (out_pop) state_r <= S_OUT2;
        S_OUT2: if (out_pop) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/tunnel_session_table.sv =====
// tunnel_session_table: client session table of a tunnel endpoint.
// A word passes the front-end queue and then the back end's event register;
// the back end serves one word at a time (match, then table write-back) and
// takes no new word until that word is done and its results have been popped.
// Reset (rst_n low, synchronous): table, ages, super client and subnet cleared.
module tunnel_session_table import tst_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_req_type,
  input  logic [63:0] in_peer_addr_hi,
  input  logic [63:0] in_peer_addr_lo,
  input  logic [15:0] in_peer_port,
  input  logic [15:0] in_pkt_length,
  input  logic [47:0] in_head_bytes,
  input  logic [3:0]  in_ip_ver,
  input  logic [7:0]  in_v4_src_last,
  input  logic [31:0] in_v4_dst_addr,
  input  logic [7:0]  in_v6_src_last,
  input  logic [7:0]  in_v6_dst_last,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  out_action,
  output logic [1:0]  out_reply_code,
  output logic [3:0]  out_slot_index,
  output logic [63:0] out_dest_addr_hi,
  output logic [63:0] out_dest_addr_lo,
  output logic [15:0] out_dest_port,
  output logic        out_last_result
);

  logic evt_valid, evt_pop;
  evt_t evt;
  res_t res;

  tst_front u_front (
    .clk, .rst_n, .cfg_we, .cfg_wdata,
    .in_push(push), .in_full(full),
    .in_req_type, .in_peer_addr_hi, .in_peer_addr_lo, .in_peer_port,
    .in_pkt_length, .in_head_bytes, .in_ip_ver, .in_v4_src_last,
    .in_v4_dst_addr, .in_v6_src_last, .in_v6_dst_last,
    .evt_valid, .evt_pop, .evt_data(evt)
  );

  tst_back u_back (
    .clk, .rst_n, .evt_valid, .evt_pop, .evt_data(evt),
    .out_empty(empty), .out_pop(pop), .res
  );

  assign out_action       = res.action;
  assign out_reply_code   = res.code;
  assign out_slot_index   = res.slot;
  assign out_dest_addr_hi = res.hi;
  assign out_dest_addr_lo = res.lo;
  assign out_dest_port    = res.port;
  assign out_last_result  = res.last;

endmodule
